[rtl/core/pnr_pkg.sv]
package pnr_pkg;

	localparam logic [15:0] OUTPUT_RATE_RST = 16'd44100;
	localparam logic [15:0] PATCH_TYPE_PCM  = 16'd3;
	localparam logic [31:0] LEN_OVERHEAD    = 32'd32;
	localparam logic [4:0]  PCM_START       = 5'd24;
	localparam logic [4:0]  HDR_CHECK_POS   = 5'd7;
	localparam logic [7:0]  SAMPLE_BIAS     = 8'h80;

	// budget only needs to cover acc + 2*src_rate, so it is saturated
	localparam int BUDGET_W = 18;
	localparam int ACC_W    = 17;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = 2;

	typedef enum logic [1:0] {
		ST_SAMPLE    = 2'd0,
		ST_BAD_TYPE  = 2'd1,
		ST_BAD_LEN   = 2'd2,
		ST_NO_SAMPLE = 2'd3
	} status_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	typedef struct packed {
		logic                is_err;
		status_t             err_status;
		logic [15:0]         sample;
		logic [15:0]         src_rate;
		logic [BUDGET_W-1:0] budget;
		logic                first;
		logic                last_byte;
	} cmd_t;

endpackage

[rtl/core/pnr_ifs.sv]
interface pnr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       patch_start;

	modport source (output valid, output data_byte, output patch_start, input ready);
	modport sink (input valid, input data_byte, input patch_start, output ready);
endinterface

interface pnr_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic [1:0]         status;
	logic               last;

	modport source (output valid, output left_sample, output right_sample,
		output status, output last, input ready);
	modport sink (input valid, input left_sample, input right_sample,
		input status, input last, output ready);
endinterface

[rtl/core/pnr_cmdq.sv]
module pnr_cmdq
	import pnr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_AW:0]   count_q;

	assign full  = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("cmdq push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid && $past(count_q) <= (CMDQ_AW+1)'(CMDQ_DEPTH))
		else $error("cmdq pop while empty");

endmodule

[rtl/core/pnr_front.sv]
module pnr_front
	import pnr_pkg::*;
#(
	parameter int MAX_RUN = 64
)
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   output_rate,
	pnr_in_if.sink        in_ch,
	output logic          push,
	output cmd_t          push_data,
	input  logic          q_full
);

	localparam int CAP_W = $clog2(MAX_RUN + 1) + 16;

	logic [4:0]  pos_q, pos_c, pos_d;
	logic [15:0] type_q, type_c, type_d;
	logic [15:0] sr_q, sr_c, sr_d;
	logic [31:0] len_q, len_c, len_d;
	logic [31:0] left_q, left_c, left_d;
	logic        done_q, done_c, done_d;
	logic        first_q, first_d;
	logic [31:0] len_full;
	logic [CAP_W-1:0] run_cap;
	logic [47:0] budget_prod;
	logic        accept;
	logic [7:0]  b;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign b           = in_ch.data_byte;

	assign len_full    = {b, len_q[23:0]};
	assign run_cap     = CAP_W'(MAX_RUN) * CAP_W'(sr_q);
	assign budget_prod = 48'(left_q) * 48'(output_rate);

	always_comb begin
		pos_c   = pos_q;
		type_c  = type_q;
		sr_c    = sr_q;
		len_c   = len_q;
		left_c  = left_q;
		done_c  = done_q;
		if (in_ch.patch_start) begin
			pos_c  = '0;
			type_c = '0;
			sr_c   = '0;
			len_c  = '0;
			left_c = '0;
			done_c = 1'b0;
		end

		pos_d     = pos_q;
		type_d    = type_q;
		sr_d      = sr_q;
		len_d     = len_q;
		left_d    = left_q;
		done_d    = done_q;
		first_d   = first_q;
		push      = 1'b0;
		push_data = '0;

		if (accept) begin
			pos_d  = pos_c;
			type_d = type_c;
			sr_d   = sr_c;
			len_d  = len_c;
			left_d = left_c;
			done_d = done_c;
			if (!done_c) begin
				if (pos_c < PCM_START) begin
					pos_d = pos_c + 5'd1;
					case (pos_c)
						5'd0: type_d[7:0]   = b;
						5'd1: type_d[15:8]  = b;
						5'd2: sr_d[7:0]     = b;
						5'd3: sr_d[15:8]    = b;
						5'd4: len_d[7:0]    = b;
						5'd5: len_d[15:8]   = b;
						5'd6: len_d[23:16]  = b;
						5'd7: len_d[31:24]  = b;
						default: ;
					endcase
					if (pos_c == HDR_CHECK_POS) begin
						if (type_c != PATCH_TYPE_PCM) begin
							push                 = 1'b1;
							push_data.is_err     = 1'b1;
							push_data.err_status = ST_BAD_TYPE;
							done_d               = 1'b1;
						end else if (len_full <= LEN_OVERHEAD || sr_c == '0 ||
							CAP_W'(output_rate) > run_cap) begin
							push                 = 1'b1;
							push_data.is_err     = 1'b1;
							push_data.err_status = ST_BAD_LEN;
							done_d               = 1'b1;
						end else begin
							left_d  = len_full - LEN_OVERHEAD;
							first_d = 1'b1;
						end
					end
				end else if (left_c == '0) begin
					done_d = 1'b1;
				end else begin
					push                = 1'b1;
					push_data.sample    = {b ^ SAMPLE_BIAS, 8'h00};
					push_data.src_rate  = sr_c;
					push_data.budget    = (budget_prod[47:BUDGET_W] != '0) ? '1 :
						budget_prod[BUDGET_W-1:0];
					push_data.first     = first_q;
					push_data.last_byte = (left_c == 32'd1);
					first_d             = 1'b0;
					left_d              = left_c - 32'd1;
					if (left_c == 32'd1) begin
						done_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			type_q  <= '0;
			sr_q    <= '0;
			len_q   <= '0;
			left_q  <= '0;
			done_q  <= 1'b1;
			first_q <= 1'b0;
		end else begin
			pos_q   <= pos_d;
			type_q  <= type_d;
			sr_q    <= sr_d;
			len_q   <= len_d;
			left_q  <= left_d;
			done_q  <= done_d;
			first_q <= first_d;
		end
	end

endmodule

[rtl/core/pnr_back.sv]
module pnr_back
	import pnr_pkg::*;
#(
	parameter int MAX_RUN = 64
)
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic [15:0]  output_rate,
	input  logic         q_valid,
	input  cmd_t         q_data,
	output logic         q_pop,
	pnr_out_if.source    out_ch
);

	localparam int IT_W = $clog2(MAX_RUN);

	back_state_t         state_q, state_d;
	cmd_t                cmd_q;
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    phase_q;
	logic [IT_W-1:0]     iter_q;
	logic                any_q;

	logic                out_valid_q;
	logic [15:0]         out_sample_q;
	status_t             out_status_q;
	logic                out_last_q;

	logic [BUDGET_W-1:0] acc0, acc1, acc2, dr, sr, acc_fin;
	logic [ACC_W-1:0]    phase_new, phase_nx;
	logic                cont, emit, next_cont, next_emit, fin;
	logic                slot_free, need_out, advance, load;
	logic [15:0]         o_sample;
	status_t             o_status;
	logic                o_last;

	assign slot_free = !out_valid_q || out_ch.ready;

	assign acc0 = BUDGET_W'(acc_q);
	assign dr   = BUDGET_W'(output_rate);
	assign sr   = BUDGET_W'(cmd_q.src_rate);
	assign acc1 = acc0 + sr;
	assign acc2 = acc0 + {sr[BUDGET_W-2:0], 1'b0};

	assign cont      = (acc0 < dr);
	assign emit      = cont && (acc1 <= cmd_q.budget);
	assign next_cont = cont && (iter_q != IT_W'(MAX_RUN - 1)) && (acc1 < dr);
	assign next_emit = next_cont && (acc2 <= cmd_q.budget);
	assign fin       = cmd_q.is_err || !next_cont;
	assign acc_fin   = cont ? acc1 : acc0;
	assign phase_new = (acc_fin >= dr) ? ACC_W'(acc_fin - dr) : '0;

	always_comb begin
		need_out = 1'b0;
		o_sample = '0;
		o_status = ST_SAMPLE;
		o_last   = 1'b0;
		if (cmd_q.is_err) begin
			need_out = 1'b1;
			o_status = cmd_q.err_status;
			o_last   = 1'b1;
		end else if (emit) begin
			need_out = 1'b1;
			o_sample = cmd_q.sample;
			o_last   = cmd_q.last_byte && !next_emit;
		end else if (fin && cmd_q.last_byte && !any_q) begin
			need_out = 1'b1;
			o_status = ST_NO_SAMPLE;
			o_last   = 1'b1;
		end
	end

	always_comb begin
		state_d  = state_q;
		advance  = 1'b0;
		load     = 1'b0;
		phase_nx = phase_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					load    = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				advance = !need_out || slot_free;
				if (advance && fin) begin
					if (!cmd_q.is_err) begin
						phase_nx = phase_new;
					end
					load    = q_valid;
					state_d = q_valid ? BK_RUN : BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			acc_q       <= '0;
			iter_q      <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_nx;
			if (load) begin
				acc_q  <= q_data.first ? '0 : phase_nx;
				iter_q <= '0;
				any_q  <= 1'b0;
			end else if (advance) begin
				acc_q  <= ACC_W'(acc1);
				iter_q <= iter_q + 1'b1;
				any_q  <= any_q | emit;
			end
			if (advance && need_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= q_data;
		end
		if (advance && need_out) begin
			out_sample_q <= o_sample;
			out_status_q <= o_status;
			out_last_q   <= o_last;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.left_sample  = out_sample_q;
	assign out_ch.right_sample = out_sample_q;
	assign out_ch.status       = out_status_q;
	assign out_ch.last         = out_last_q;

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_SAMPLE |-> out_last_q && out_sample_q == '0)
		else $error("error item without last or with nonzero sample");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid && (state_q == BK_IDLE || fin))
		else $error("command taken while previous one still running");

endmodule

[rtl/core/pcm_patch_nearest_resampler.sv]
// channel  dir  payload                                        accepted when
// in_ch    in   data_byte[7:0], patch_start                    valid && ready
// out_ch   out  left_sample, right_sample, status[1:0], last   valid && ready
// cfg      in   cfg_wdata[15:0] = output_rate                  cfg_we
//
// Header bytes are parsed in the front end.
// A sample byte runs k phase steps in the back end, k being about output_rate / source_rate
// and at most MAX_RUN; one output per cycle while out_ch is not stalled.
// A four-entry command queue sits between the two; in_ch.ready drops when it is full.
// out_ch is registered; a stalled output holds the back end only.
// arst_n clears all control state; output_rate resets to 44100.
module pcm_patch_nearest_resampler
	import pnr_pkg::*;
#(
	parameter int MAX_RUN = 64
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	pnr_in_if.sink      in_ch,
	pnr_out_if.source   out_ch
);

	logic [15:0] output_rate_q;
	logic        push;
	cmd_t        push_data;
	logic        q_full;
	logic        q_pop;
	logic        q_valid;
	cmd_t        q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_rate_q <= OUTPUT_RATE_RST;
		end else if (cfg_we) begin
			output_rate_q <= cfg_wdata;
		end
	end

	pnr_front #(.MAX_RUN(MAX_RUN)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.output_rate (output_rate_q),
		.in_ch       (in_ch),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	pnr_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	pnr_back #(.MAX_RUN(MAX_RUN)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.output_rate (output_rate_q),
		.q_valid     (q_valid),
		.q_data      (q_head),
		.q_pop       (q_pop),
		.out_ch      (out_ch)
	);

endmodule
